/* hdl/tlvkf_pkg.sv */
`default_nettype none

package tlvkf_pkg;

	localparam int unsigned WORD_W = 16;
	localparam int unsigned CNT_W  = 15;
	localparam int unsigned KB_W   = 17;
	localparam int unsigned LEN_W  = 24;

	localparam logic [WORD_W-1:0] MARKER   = 16'hffff;
	localparam logic [WORD_W-1:0] SEC_MASK = 16'hff00;
	localparam logic [KB_W-1:0]   KB_MAX   = 17'h1ffff;
	localparam logic [LEN_W-1:0]  LEN_MAX  = 24'hffffff;
	localparam logic [LEN_W-1:0]  LEN_INIT = 24'd4;

	typedef enum logic [1:0] {
		CFG_TARGET_SECTION = 2'd0,
		CFG_TARGET_KEY     = 2'd1,
		CFG_MAX_VALUES     = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_VALUE   = 2'd0,
		ST_MISSING = 2'd1,
		ST_END     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_TS0      = 4'd0,
		PH_TS1      = 4'd1,
		PH_SEC_ID   = 4'd2,
		PH_SEC_SIZE = 4'd3,
		PH_SKIP     = 4'd4,
		PH_KEY_ID   = 4'd5,
		PH_KEY_SIZE = 4'd6,
		PH_KEY_SKIP = 4'd7,
		PH_VALUES   = 4'd8,
		PH_DONE     = 4'd9
	} phase_t;

	typedef struct packed {
		logic [WORD_W-1:0] image_word;
		logic              first;
	} in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] value;
		logic              last;
		logic [LEN_W-1:0]  image_length;
		logic              section_found;
	} out_t;

endpackage

`default_nettype wire

/* hdl/tlvkf_parser.sv */
`default_nettype none

module tlvkf_parser (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic [15:0]               word,
	input  wire logic                      first,
	input  wire logic [15:0]               target_section,
	input  wire logic [15:0]               target_key,
	input  wire logic [14:0]               max_values,
	output logic                           res_valid,
	output tlvkf_pkg::out_t                res
);
	import tlvkf_pkg::*;

	phase_t              phase_q, c_phase, n_phase;
	logic [WORD_W-1:0]   hid_q, c_hid, n_hid;
	logic [CNT_W-1:0]    swl_q, c_swl, n_swl;
	logic [KB_W-1:0]     kb_q, c_kb, n_kb;
	logic [WORD_W-1:0]   khid_q, c_khid, n_khid;
	logic [CNT_W-1:0]    vwl_q, c_vwl, n_vwl;
	logic [CNT_W-1:0]    ve_q, c_ve, n_ve;
	logic                sm_q, c_sm, n_sm;
	logic                ksd_q, c_ksd, n_ksd;
	logic [LEN_W-1:0]    len_q, c_len, n_len;

	logic [CNT_W-1:0]    words, swl_dec, vwl_dec, ve_inc;
	logic [KB_W:0]       kb_sum;
	logic [KB_W-1:0]     kb_new;
	logic [LEN_W:0]      len_sum, len_fin;
	logic [LEN_W-1:0]    len_new, len_end;
	logic                sec_end, key_end, sec_hit, key_hit;
	logic                more_new, more_cur, value_ok;

	// first restarts the parse on this very word
	assign c_phase = first ? PH_TS0 : phase_q;
	assign c_hid   = first ? '0 : hid_q;
	assign c_swl   = first ? '0 : swl_q;
	assign c_kb    = first ? '0 : kb_q;
	assign c_khid  = first ? '0 : khid_q;
	assign c_vwl   = first ? '0 : vwl_q;
	assign c_ve    = first ? '0 : ve_q;
	assign c_sm    = first ? 1'b0 : sm_q;
	assign c_ksd   = first ? 1'b0 : ksd_q;
	assign c_len   = first ? LEN_INIT : len_q;

	assign words   = word[WORD_W-1:1];
	assign swl_dec = c_swl - 1'b1;
	assign vwl_dec = c_vwl - 1'b1;
	assign ve_inc  = c_ve + 1'b1;

	assign kb_sum  = {1'b0, c_kb} + {2'b0, word} + 18'd4;
	assign kb_new  = (kb_sum > {1'b0, KB_MAX}) ? KB_MAX : kb_sum[KB_W-1:0];
	assign len_sum = {1'b0, c_len} + {9'b0, word} + 25'd4;
	assign len_new = (len_sum > {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[LEN_W-1:0];
	assign len_fin = {1'b0, c_len} + 25'd4;
	assign len_end = (len_fin > {1'b0, LEN_MAX}) ? LEN_MAX : len_fin[LEN_W-1:0];

	assign sec_end  = (c_hid == MARKER) && (word == MARKER);
	assign key_end  = (c_khid == MARKER) && (word == MARKER);
	assign sec_hit  = !c_sm && ((c_hid & SEC_MASK) == target_section);
	assign key_hit  = (c_khid == target_key);
	assign more_new = kb_new < {1'b0, c_hid};
	assign more_cur = c_kb < {1'b0, c_hid};
	assign value_ok = c_ve < max_values;

	// next state
	always_comb begin
		n_phase = c_phase;
		n_hid   = c_hid;
		n_swl   = c_swl;
		n_kb    = c_kb;
		n_khid  = c_khid;
		n_vwl   = c_vwl;
		n_ve    = c_ve;
		n_sm    = c_sm;
		n_ksd   = c_ksd;
		n_len   = c_len;
		case (c_phase)
			PH_TS0: n_phase = PH_TS1;
			PH_TS1: n_phase = PH_SEC_ID;
			PH_SEC_ID: begin
				n_hid   = word;
				n_phase = PH_SEC_SIZE;
			end
			PH_SEC_SIZE: begin
				if (sec_end) begin
					n_phase = PH_DONE;
				end else begin
					n_len = len_new;
					if (sec_hit) begin
						n_sm  = 1'b1;
						n_hid = word;
						n_kb  = '0;
						if (words == '0) begin
							n_ksd   = 1'b1;
							n_phase = PH_SEC_ID;
						end else begin
							n_ksd   = 1'b0;
							n_swl   = words;
							n_phase = PH_KEY_ID;
						end
					end else if (words == '0) begin
						n_phase = PH_SEC_ID;
					end else begin
						n_swl   = words;
						n_phase = PH_SKIP;
					end
				end
			end
			PH_SKIP, PH_KEY_ID, PH_KEY_SIZE, PH_KEY_SKIP, PH_VALUES: begin
				n_swl = swl_dec;
				case (c_phase)
					PH_KEY_ID: begin
						n_khid  = word;
						n_phase = PH_KEY_SIZE;
					end
					PH_KEY_SIZE: begin
						if (key_end) begin
							n_phase = PH_SKIP;
							n_ksd   = 1'b1;
						end else if (key_hit) begin
							n_ksd   = 1'b1;
							n_vwl   = words;
							n_ve    = '0;
							n_phase = (words != '0) ? PH_VALUES : PH_SKIP;
						end else begin
							n_kb  = kb_new;
							n_vwl = words;
							if (words != '0) begin
								n_phase = PH_KEY_SKIP;
							end else if (more_new) begin
								n_phase = PH_KEY_ID;
							end else begin
								n_phase = PH_SKIP;
								n_ksd   = 1'b1;
							end
						end
					end
					PH_KEY_SKIP: begin
						n_vwl = vwl_dec;
						if (vwl_dec == '0) begin
							if (more_cur) begin
								n_phase = PH_KEY_ID;
							end else begin
								n_phase = PH_SKIP;
								n_ksd   = 1'b1;
							end
						end
					end
					PH_VALUES: begin
						n_vwl = vwl_dec;
						if (value_ok) n_ve = ve_inc;
						if (vwl_dec == '0) n_phase = PH_SKIP;
					end
					default: ;
				endcase
				// section exhausted: back to the next header
				if (swl_dec == '0) begin
					n_phase = PH_SEC_ID;
					if (c_sm) n_ksd = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		logic done_k;
		done_k               = c_ksd;
		res_valid            = 1'b0;
		res                  = '0;
		res.status           = ST_VALUE;
		case (c_phase)
			PH_SEC_SIZE: begin
				if (sec_end) begin
					res_valid         = 1'b1;
					res.status        = ST_END;
					res.image_length  = len_end;
					res.section_found = c_sm;
				end else if (sec_hit && words == '0) begin
					res_valid  = 1'b1;
					res.status = ST_MISSING;
				end
			end
			PH_SKIP, PH_KEY_ID, PH_KEY_SIZE, PH_KEY_SKIP, PH_VALUES: begin
				case (c_phase)
					PH_KEY_SIZE: begin
						if (key_end) begin
							res_valid = 1'b1;
							done_k    = 1'b1;
						end else if (key_hit) begin
							done_k = 1'b1;
						end else if (words == '0 && !more_new) begin
							res_valid = 1'b1;
							done_k    = 1'b1;
						end
						res.status = ST_MISSING;
					end
					PH_KEY_SKIP: begin
						if (vwl_dec == '0 && !more_cur) begin
							res_valid = 1'b1;
							done_k    = 1'b1;
						end
						res.status = ST_MISSING;
					end
					PH_VALUES: begin
						if (value_ok) begin
							res_valid = 1'b1;
							res.value = word;
							res.last  = (ve_inc == max_values) || (vwl_dec == '0) ||
								(swl_dec == '0);
						end
					end
					default: ;
				endcase
				if (swl_dec == '0 && c_sm && !done_k && !res_valid) begin
					res_valid  = 1'b1;
					res.status = ST_MISSING;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TS0;
			hid_q   <= '0;
			swl_q   <= '0;
			kb_q    <= '0;
			khid_q  <= '0;
			vwl_q   <= '0;
			ve_q    <= '0;
			sm_q    <= 1'b0;
			ksd_q   <= 1'b0;
			len_q   <= LEN_INIT;
		end else if (en) begin
			phase_q <= n_phase;
			hid_q   <= n_hid;
			swl_q   <= n_swl;
			kb_q    <= n_kb;
			khid_q  <= n_khid;
			vwl_q   <= n_vwl;
			ve_q    <= n_ve;
			sm_q    <= n_sm;
			ksd_q   <= n_ksd;
			len_q   <= n_len;
		end
	end

endmodule

`default_nettype wire

/* hdl/tlv_config_section_key_finder.sv */
// An accepted word is held in the word register; its result is loaded into the result register when it advances.
// Throughput: one word per cycle; the word register and the result register are each one
// deep, and a word waits only while a result is held by out_stall.
// Reset (arst_n low): parse restarts at the first timestamp word, length count at 4,
// target_section and target_key 0, max_values 1, both registers empty.
`default_nettype none

module tlv_config_section_key_finder (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire tlvkf_pkg::in_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output tlvkf_pkg::out_t      out_data,
	input  wire logic            cfg_write,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [15:0]     cfg_data
);
	import tlvkf_pkg::*;

	logic [WORD_W-1:0] target_section_q, target_key_q;
	logic [CNT_W-1:0]  max_values_q;
	logic              valid_s1;
	in_t               data_s1;
	logic              advance, accept;
	logic              res_valid;
	out_t              res;
	logic              out_valid_q;
	out_t              out_data_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_section_q <= '0;
			target_key_q     <= '0;
			max_values_q     <= 15'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TARGET_SECTION: target_section_q <= cfg_data;
				CFG_TARGET_KEY:     target_key_q     <= cfg_data;
				CFG_MAX_VALUES:     max_values_q     <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) data_s1 <= in_data;
	end

	tlvkf_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (advance),
		.word           (data_s1.image_word),
		.first          (data_s1.first),
		.target_section (target_section_q),
		.target_key     (target_key_q),
		.max_values     (max_values_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	// result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_data_q <= res;
	end

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held word and a blocked result");

	a_last_only_on_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last) |-> (out_data.status == ST_VALUE))
		else $error("last flag set on a non-value result");

	a_end_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_END) |-> (out_data.image_length >= 24'd8))
		else $error("image end reported with length below header and marker");

	a_held_word_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> (!valid_s1 || $past(accept)))
		else $error("held word failed to advance into an empty result register");

endmodule

`default_nettype wire

/* sim/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tlvkf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = CFG_TARGET_SECTION;
	logic [15:0] cfg_data = '0;

	tlv_config_section_key_finder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// pending image words and the parser reports they must cause
	in_t  word_q[$];
	out_t report_q[$];
	logic [15:0] body_q[$];
	int   queued;
	int   errors;

	// stimulus knobs
	bit   idle_on;
	bit   want_hold;
	bit   hold_done;
	bit   took;
	int   gap_left;
	int   stall_left;
	int   hold_left;

	// parser copy: configuration
	logic [15:0] tgt_sec = '0;
	logic [15:0] tgt_key = '0;
	logic [14:0] max_vals = 15'd1;

	// parser copy: walk state
	phase_t      ph;
	logic [15:0] hdr_id;
	logic [14:0] sec_left;
	logic [16:0] kb_seen;
	logic [15:0] key_id;
	logic [14:0] val_left;
	logic [14:0] val_cnt;
	bit          sec_match;
	bit          key_done;
	logic [23:0] len_tot;
	bit          posted;

	task automatic clear_parse();
		ph = PH_TS0;
		hdr_id = '0;
		sec_left = '0;
		kb_seen = '0;
		key_id = '0;
		val_left = '0;
		val_cnt = '0;
		sec_match = 1'b0;
		key_done = 1'b0;
		len_tot = LEN_INIT;
	endtask

	task automatic post_report(status_t st, logic [15:0] v, logic l, logic [23:0] len, logic f);
		out_t r;
		r.status = st;
		r.value = v;
		r.last = l;
		r.image_length = len;
		r.section_found = f;
		report_q.push_back(r);
		posted = 1'b1;
	endtask

	task automatic key_absent();
		key_done = 1'b1;
		post_report(ST_MISSING, '0, 1'b0, '0, 1'b0);
	endtask

	task automatic close_key();
		if (kb_seen < {1'b0, hdr_id}) begin
			ph = PH_KEY_ID;
		end else begin
			ph = PH_SKIP;
			key_absent();
		end
	endtask

	task automatic parse_word(in_t it);
		logic [15:0] w;
		logic [14:0] words;
		int          acc;
		bit          walk;
		w = it.image_word;
		words = w[15:1];
		posted = 1'b0;
		walk = 1'b0;
		if (it.first)
			clear_parse();
		case (ph)
			PH_TS0: ph = PH_TS1;
			PH_TS1: ph = PH_SEC_ID;
			PH_SEC_ID: begin
				hdr_id = w;
				ph = PH_SEC_SIZE;
			end
			PH_SEC_SIZE: begin
				if (hdr_id == MARKER && w == MARKER) begin
					acc = int'(len_tot) + 4;
					ph = PH_DONE;
					post_report(ST_END, '0, 1'b0, (acc > LEN_MAX) ? LEN_MAX : acc[23:0],
						sec_match);
				end else begin
					acc = int'(len_tot) + 4 + int'(w);
					len_tot = (acc > LEN_MAX) ? LEN_MAX : acc[23:0];
					if (!sec_match && (hdr_id & SEC_MASK) == tgt_sec) begin
						// matched section: header_id now holds its byte size
						sec_match = 1'b1;
						hdr_id = w;
						kb_seen = '0;
						key_done = 1'b0;
						if (words == 0) begin
							ph = PH_SEC_ID;
							key_absent();
						end else begin
							sec_left = words;
							ph = PH_KEY_ID;
						end
					end else if (words == 0) begin
						ph = PH_SEC_ID;
					end else begin
						sec_left = words;
						ph = PH_SKIP;
					end
				end
			end
			PH_SKIP, PH_KEY_ID, PH_KEY_SIZE, PH_KEY_SKIP, PH_VALUES: walk = 1'b1;
			default: ;
		endcase
		if (walk) begin
			sec_left = sec_left - 15'd1;
			case (ph)
				PH_KEY_ID: begin
					key_id = w;
					ph = PH_KEY_SIZE;
				end
				PH_KEY_SIZE: begin
					if (key_id == MARKER && w == MARKER) begin
						ph = PH_SKIP;
						key_absent();
					end else if (key_id == tgt_key) begin
						key_done = 1'b1;
						val_left = words;
						val_cnt = '0;
						ph = (val_left != 0) ? PH_VALUES : PH_SKIP;
					end else begin
						acc = int'(kb_seen) + 4 + int'(w);
						kb_seen = (acc > KB_MAX) ? KB_MAX : acc[16:0];
						val_left = words;
						if (val_left != 0)
							ph = PH_KEY_SKIP;
						else
							close_key();
					end
				end
				PH_KEY_SKIP: begin
					val_left = val_left - 15'd1;
					if (val_left == 0)
						close_key();
				end
				PH_VALUES: begin
					val_left = val_left - 15'd1;
					if (val_cnt < max_vals) begin
						post_report(ST_VALUE, w, (int'(val_cnt) + 1 == int'(max_vals)) ||
							val_left == 0 || sec_left == 0, '0, 1'b0);
						val_cnt = val_cnt + 15'd1;
					end
					if (val_left == 0)
						ph = PH_SKIP;
				end
				default: ;
			endcase
			if (sec_left == 0) begin
				ph = PH_SEC_ID;
				if (sec_match && !key_done && !posted)
					key_absent();
			end
		end
	endtask

	task automatic mismatch(string msg);
		if (errors < 50)
			$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic cmp_field(string name, logic [23:0] got, logic [23:0] want);
		if (got !== want)
			mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic check_report(out_t got);
		out_t want;
		if (report_q.size() == 0) begin
			mismatch($sformatf("unexpected word %h", got));
			return;
		end
		want = report_q.pop_front();
		cmp_field("status", got.status, want.status);
		cmp_field("value", got.value, want.value);
		cmp_field("last", got.last, want.last);
		cmp_field("image_length", got.image_length, want.image_length);
		cmp_field("section_found", got.section_found, want.section_found);
	endtask

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	// sample both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_word(in_data);
				took = 1'b1;
			end
			if (out_valid && !out_stall)
				check_report(out_data);
		end
	end

	// word driver: hold until accepted, then gap or advance
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took)) begin
			took = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (word_q.size() > 0) begin
				in_data <= word_q.pop_front();
				in_valid <= 1'b1;
				gap_left = pick_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver stall
	always @(negedge clk) begin
		if (want_hold && !hold_done) begin
			hold_left = 300;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (stall_left == 0 && $urandom_range(0, 2) == 0)
				stall_left = pick_len();
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push(logic [15:0] w, logic f);
		in_t it;
		it.image_word = w;
		it.first = f;
		word_q.push_back(it);
		queued++;
	endtask

	task automatic drain();
		while (word_q.size() != 0 || in_valid || report_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_TARGET_SECTION: tgt_sec = val;
			CFG_TARGET_KEY:     tgt_key = val;
			CFG_MAX_VALUES:     max_vals = val[14:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] sec, logic [15:0] key, logic [15:0] maxv);
		write_reg(CFG_TARGET_SECTION, sec);
		write_reg(CFG_TARGET_KEY, key);
		write_reg(CFG_MAX_VALUES, maxv);
	endtask

	// one image: timestamps, a few sections, usually an end marker
	task automatic build_image();
		int          nsec, nkeys, nvals, pick;
		logic [7:0]  lowb;
		logic [15:0] id, size, kid, ksize;
		push(16'($urandom), 1'b1);
		push(16'($urandom), 1'b0);
		nsec = $urandom_range(0, 4);
		repeat (nsec) begin
			pick = $urandom_range(0, 9);
			lowb = 8'($urandom_range(0, 255));
			if (pick < 5)
				id = {tgt_sec[15:8], lowb};
			else if (pick == 5)
				id = MARKER;
			else
				id = 16'($urandom);
			body_q.delete();
			if (pick < 7) begin
				nkeys = $urandom_range(0, 4);
				repeat (nkeys) begin
					pick = $urandom_range(0, 9);
					nvals = $urandom_range(0, 5);
					if (pick < 4)
						kid = tgt_key;
					else if (pick == 4)
						kid = MARKER;
					else if (pick < 7)
						kid = 16'($urandom_range(0, 3));
					else
						kid = 16'($urandom);
					ksize = 16'(2 * nvals + $urandom_range(0, 1));
					if (kid == MARKER && $urandom_range(0, 1) == 0) begin
						ksize = MARKER;
						nvals = 0;
					end
					// lie about the key length now and then
					if ($urandom_range(0, 9) == 0)
						ksize = 16'($urandom_range(0, 40));
					body_q.push_back(kid);
					body_q.push_back(ksize);
					repeat (nvals) body_q.push_back(16'($urandom));
				end
				size = 16'(2 * body_q.size() + $urandom_range(0, 1));
				if ($urandom_range(0, 7) == 0)
					size = 16'($urandom_range(0, 2 * size + 4));
			end else begin
				size = 16'($urandom_range(0, 24));
				repeat (size / 2) body_q.push_back(16'($urandom));
			end
			push(id, 1'b0);
			push(size, 1'b0);
			foreach (body_q[i]) push(body_q[i], 1'b0);
		end
		// truncated images get restarted by the next first word
		if ($urandom_range(0, 9) != 0) begin
			push(MARKER, 1'b0);
			push(MARKER, 1'b0);
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 3)) push(16'($urandom), 1'b0);
		end
	endtask

	initial begin
		int start;
		clear_parse();
		errors = 0;
		queued = 0;
		idle_on = 1'b1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed image with reset settings, starting without a first flag
		push(16'h0000, 1'b0);
		push(16'hffff, 1'b0);
		push(16'h00ff, 1'b0);  // matched section with one byte: key missing
		push(16'h0001, 1'b0);
		push(MARKER, 1'b0);
		push(MARKER, 1'b0);
		push(16'ha5a5, 1'b0);  // ignored after end
		push(16'h5a5a, 1'b1);
		push(16'h0001, 1'b0);
		push(MARKER, 1'b0);    // marker id with a real size is a plain section
		push(16'h0002, 1'b0);
		push(16'h8001, 1'b0);
		push(16'h0042, 1'b0);
		push(16'h000c, 1'b0);
		push(16'h0007, 1'b0);
		push(16'h0003, 1'b0);
		push(16'h1234, 1'b0);
		push(16'h0000, 1'b0);
		push(16'h0004, 1'b0);
		push(16'hbeef, 1'b0);
		push(16'hcafe, 1'b0);
		push(16'h0033, 1'b0);  // 0xcafe heads another section; this is its size
		push(16'h0000, 1'b0);
		push(MARKER, 1'b0);
		push(MARKER, 1'b0);

		for (int p = 1; p <= 9; p++) begin
			drain();
			idle_on = !(p == 5 || p == 6 || p == 9);
			case (p)
				1: set_config(16'hff00, 16'hffff, 16'hffff);
				2: set_config(16'h0000, 16'h0000, 16'h0000);
				3: set_config(16'h12ab, 16'($urandom), 16'd3);
				9: set_config(16'hff00, 16'($urandom), 16'h7fff);
				default: set_config({8'($urandom_range(0, 255)), 8'h00},
					(p % 2 == 1) ? 16'($urandom) : 16'($urandom_range(0, 3)),
					16'($urandom_range(1, 6)));
			endcase
			if (p == 5)
				want_hold = 1'b1;
			if (p == 9) begin
				// largest sizes, cut short by a restart
				push(16'($urandom), 1'b1);
				push(16'($urandom), 1'b0);
				push(16'h1234, 1'b0);
				push(16'hffff, 1'b0);
				repeat (20) push(16'($urandom), 1'b0);
				push(16'($urandom), 1'b1);
				push(16'($urandom), 1'b0);
				push(16'hff77, 1'b0);
				push(16'hfffe, 1'b0);
				push(tgt_key, 1'b0);
				push(16'hfffe, 1'b0);
				repeat (20) push(16'($urandom), 1'b0);
				// key running past its section
				push(16'($urandom), 1'b1);
				push(16'($urandom), 1'b0);
				push(16'hff01, 1'b0);
				push(16'h0010, 1'b0);
				push(tgt_key, 1'b0);
				push(16'h0020, 1'b0);
				repeat (6) push(16'($urandom), 1'b0);
				push(MARKER, 1'b0);
				push(MARKER, 1'b0);
			end else begin
				start = queued;
				while (queued - start < 250) begin
					if ($urandom_range(0, 19) == 0)
						repeat ($urandom_range(4, 16))
							push(16'($urandom), $urandom_range(0, 9) == 0);
					else
						build_image();
				end
			end
		end
		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
hdl/tlvkf_pkg.sv
hdl/tlvkf_parser.sv
hdl/tlv_config_section_key_finder.sv
sim/testbench.sv
